[sv/i2c_master_write_sequencer_core_assert.svh]
// ----------------------------------------------------------------------------
// I2C write sequencer assertion macros
// Clocked property wrappers shared by the checker.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_WRITE_SEQUENCER_CORE_ASSERT_SVH
`define I2C_MASTER_WRITE_SEQUENCER_CORE_ASSERT_SVH

// checked only out of reset
`define I2CWS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every edge, reset included
`define I2CWS_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/i2cws_pkg.sv]
// ----------------------------------------------------------------------------
// i2cws_pkg
// Command codes and queue entry type of the I2C write sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cws_pkg;

	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_STOP  = 2'd1;
	localparam logic [1:0] KIND_WRITE = 2'd2;

	localparam logic [3:0] ACK_BIT    = 4'd8;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
	} cmd_t;

endpackage

`default_nettype wire

[sv/i2c_master_write_sequencer_core.sv]
// A command's input beat is registered in the front stage, then in the queue, and its
// first pin-state beat is registered at the back output. Beats are paced by the hold
// counter; a byte write issues 27 beats, a start 3 and a stop 2.
// Input beats enter every cycle while the two-entry queue and front stage have room.
// Reset (arst_n low, asynchronous) empties the queue and sets scl_q, sda_q idle high.
// ----------------------------------------------------------------------------
// i2c_master_write_sequencer_core
// Write-only I2C master: turns start, stop and byte commands into timed pin states.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_write_sequencer_core import i2cws_pkg::*; #(
	parameter int HOLD_CYCLES = 50
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output      logic       in_stall,
	input  wire logic [1:0] kind,
	input  wire logic [7:0] data_byte,
	output      logic       out_valid,
	input  wire logic       out_stall,
	output      logic       scl_level,
	output      logic       sda_level,
	output      logic       last_step
);

	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;
	logic pop_valid;
	logic pop;
	cmd_t pop_cmd;

	i2cws_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.data_byte  (data_byte),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	i2cws_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_cmd    (pop_cmd)
	);

	i2cws_back #(
		.HOLD_CYCLES (HOLD_CYCLES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop       (pop),
		.pop_cmd   (pop_cmd),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.scl_level (scl_level),
		.sda_level (sda_level),
		.last_step (last_step)
	);

endmodule

`default_nettype wire

[sv/i2cws_front.sv]
// ----------------------------------------------------------------------------
// i2cws_front
// Input stage: takes command beats, drops unknown codes, feeds the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cws_front import i2cws_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output      logic       in_stall,
	input  wire logic [1:0] kind,
	input  wire logic [7:0] data_byte,
	output      logic       push_valid,
	input  wire logic       push_ready,
	output      cmd_t       push_cmd
);

	logic valid_s1;
	cmd_t cmd_s1;
	logic load;
	logic known;

	assign in_stall = valid_s1 && !push_ready;
	assign load     = in_valid && !in_stall;
	assign known    = (kind == KIND_START) || (kind == KIND_STOP) || (kind == KIND_WRITE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= known;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cmd_s1.kind <= kind;
			cmd_s1.data <= (kind == KIND_WRITE) ? data_byte : 8'd0;
		end
	end

	assign push_valid = valid_s1;
	assign push_cmd   = cmd_s1;

endmodule

`default_nettype wire

[sv/i2cws_fifo.sv]
// ----------------------------------------------------------------------------
// i2cws_fifo
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cws_fifo import i2cws_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push_valid,
	output      logic push_ready,
	input  wire cmd_t push_cmd,
	output      logic pop_valid,
	input  wire logic pop,
	output      cmd_t pop_cmd
);

	cmd_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;
	assign pop_cmd    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

[sv/i2cws_back.sv]
// ----------------------------------------------------------------------------
// i2cws_back
// Pin sequencer: steps through each command and paces the pin-state beats.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cws_back import i2cws_pkg::*; #(
	parameter int HOLD_CYCLES = 50
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic pop_valid,
	output      logic pop,
	input  wire cmd_t pop_cmd,
	output      logic out_valid,
	input  wire logic out_stall,
	output      logic scl_level,
	output      logic sda_level,
	output      logic last_step
);

	localparam int HW = (HOLD_CYCLES > 1) ? $clog2(HOLD_CYCLES) : 1;
	// beat taken, hold_q counts down from HOLD_RELOAD, then the next beat issues
	localparam logic [HW-1:0] HOLD_RELOAD = HW'((HOLD_CYCLES > 2) ? HOLD_CYCLES - 2 : 0);
	localparam bit GAPLESS = (HOLD_CYCLES == 1);

	logic          busy_q;
	logic [1:0]    kind_q;
	logic [7:0]    shreg_q;
	logic [3:0]    bit_q;
	logic [1:0]    ph_q;
	logic          scl_q;
	logic          sda_q;
	logic [HW-1:0] hold_q;
	logic          out_valid_q;
	logic          scl_level_q;
	logic          sda_level_q;
	logic          last_step_q;

	logic nscl;
	logic nsda;
	logic nlast;
	logic out_take;
	logic slot_free;
	logic emit;

	assign out_take  = out_valid_q && !out_stall;
	assign slot_free = (hold_q == '0) && (!out_valid_q || (out_take && GAPLESS));
	assign emit      = busy_q && slot_free;
	assign pop       = pop_valid && (!busy_q || (emit && nlast));

	always_comb begin
		nscl  = scl_q;
		nsda  = sda_q;
		nlast = 1'b0;
		unique case (kind_q)
			KIND_START: begin
				case (ph_q)
					2'd0: begin
						nscl = 1'b1;
						nsda = 1'b1;
					end
					2'd1: nsda = 1'b0;
					default: begin
						nscl  = 1'b0;
						nlast = 1'b1;
					end
				endcase
			end
			KIND_STOP: begin
				case (ph_q)
					2'd0: begin
						nscl = 1'b1;
						nsda = 1'b0;
					end
					default: begin
						nsda  = 1'b1;
						nlast = 1'b1;
					end
				endcase
			end
			KIND_WRITE: begin
				case (ph_q)
					2'd0:    nsda = (bit_q == ACK_BIT) ? 1'b1 : shreg_q[7];
					2'd1:    nscl = 1'b1;
					default: begin
						nscl  = 1'b0;
						nlast = (bit_q == ACK_BIT);
					end
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			ph_q        <= 2'd0;
			bit_q       <= 4'd0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			hold_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_take) begin
				hold_q <= HOLD_RELOAD;
			end else if (hold_q != '0) begin
				hold_q <= hold_q - HW'(1);
			end

			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end

			if (pop) begin
				busy_q <= 1'b1;
				ph_q   <= 2'd0;
				bit_q  <= 4'd0;
			end else if (emit) begin
				if (nlast) begin
					busy_q <= 1'b0;
				end
				if (kind_q == KIND_WRITE && ph_q == 2'd2) begin
					ph_q  <= 2'd0;
					bit_q <= bit_q + 4'd1;
				end else begin
					ph_q <= ph_q + 2'd1;
				end
			end

			if (emit) begin
				scl_q <= nscl;
				sda_q <= nsda;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q  <= pop_cmd.kind;
			shreg_q <= pop_cmd.data;
		end else if (emit && kind_q == KIND_WRITE && ph_q == 2'd2) begin
			shreg_q <= {shreg_q[6:0], 1'b0};
		end
		if (emit) begin
			scl_level_q <= nscl;
			sda_level_q <= nsda;
			last_step_q <= nlast;
		end
	end

	assign out_valid = out_valid_q;
	assign scl_level = scl_level_q;
	assign sda_level = sda_level_q;
	assign last_step = last_step_q;

endmodule

`default_nettype wire

[sv/i2cws_checker.sv]
// ----------------------------------------------------------------------------
// i2cws_checker
// Port-level checks of the I2C write sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "i2c_master_write_sequencer_core_assert.svh"

module i2cws_checker #(
	parameter int HOLD_CYCLES = 50
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic scl_level,
	input wire logic sda_level,
	input wire logic last_step
);

	`I2CWS_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(scl_level) && $stable(sda_level) && $stable(last_step), "stalled beat changed")
	`I2CWS_ASSERT(a_last_shape, out_valid && last_step |-> !(scl_level && !sda_level), "command ended with SDA low under SCL high")
	`I2CWS_ASSERT(a_pacing, (HOLD_CYCLES > 1) && out_valid && !out_stall |=> !out_valid, "beat issued inside hold interval")
	`I2CWS_ASSERT_ALWAYS(a_reset_empty, $rose(arst_n) |-> !out_valid, "beat present on leaving reset")

endmodule

bind i2c_master_write_sequencer_core i2cws_checker #(
	.HOLD_CYCLES (HOLD_CYCLES)
) u_i2cws_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.scl_level (scl_level),
	.sda_level (sda_level),
	.last_step (last_step)
);

`default_nettype wire
